[hw/rtl/tcw_pkg.sv]
// Shared constants, payload types and controller state type for the text console writer.
package tcw_pkg;

  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  localparam int unsigned KEEP_COUNT = CELL_COUNT - COLUMNS;

  localparam int unsigned ADDR_W = $clog2(CELL_COUNT);
  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned CUR_W  = 11;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CELL_W = 16;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] BLANK_ATTR   = 8'h07;
  localparam logic [CHAR_W-1:0] TEXT_ATTR    = 8'h0A;
  localparam logic [CELL_W-1:0] BLANK_CELL   = {BLANK_ATTR, CH_SPACE};

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } in_word_t;

  typedef struct packed {
    logic [CUR_W-1:0]  cursor;
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_attr;
  } out_word_t;

  typedef struct packed {
    logic      idle;
    logic      res_valid;
    out_word_t res_word;
  } ctrl_stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_BLANK,
    ST_EXEC
  } state_e;

endpackage

[hw/rtl/tcw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/tcw_ctrl.sv]
// Sequencer: screen clear, scroll copy, cursor update, cell reads and cell writes.
module tcw_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  tcw_pkg::in_word_t             in_word_i,
  input  logic                          cfg_we_i,
  input  logic [tcw_pkg::CUR_W-1:0]     cfg_wdata_i,
  output tcw_pkg::ctrl_stat_t           stat_o,
  output logic                          mem_we_o,
  output logic [tcw_pkg::ADDR_W-1:0]    mem_waddr_o,
  output logic [tcw_pkg::CELL_W-1:0]    mem_wdata_o,
  output logic                          mem_re_o,
  output logic [tcw_pkg::ADDR_W-1:0]    mem_raddr_o,
  input  logic [tcw_pkg::CELL_W-1:0]    mem_rdata_i
);

  localparam int unsigned AW = tcw_pkg::ADDR_W;
  localparam int unsigned CW = tcw_pkg::CUR_W;
  localparam int unsigned LW = tcw_pkg::COL_W;

  tcw_pkg::state_e state_q, state_d;

  logic [AW-1:0]                  cnt_q, cnt_d;
  logic [CW-1:0]                  cursor_q, cursor_d;
  logic [LW-1:0]                  col_q, col_d;
  logic [CW-1:0]                  in_start_q;
  logic [tcw_pkg::CHAR_W-1:0]     ch_q;
  logic                           oob_q;
  logic                           pend_q;
  logic [AW-1:0]                  paddr_q;

  logic cnt_last;
  logic cnt_keep;
  logic cursor_full;
  logic in_oob;
  logic bs_allowed;

  assign cnt_last    = (cnt_q == AW'(tcw_pkg::CELL_COUNT - 1));
  assign cnt_keep    = (cnt_q == AW'(tcw_pkg::KEEP_COUNT));
  assign cursor_full = (cursor_q >= CW'(tcw_pkg::CELL_COUNT));
  assign in_oob      = (in_word_i.cell_index >= tcw_pkg::IDX_W'(tcw_pkg::CELL_COUNT));
  assign bs_allowed  = (cursor_q > in_start_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcw_pkg::ST_CLEAR: begin
        if (cnt_last) state_d = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (accept_i) begin
          if (in_word_i.kind == tcw_pkg::KIND_READ) begin
            state_d = tcw_pkg::ST_READ;
          end else if (cursor_full) begin
            state_d = tcw_pkg::ST_SCROLL;
          end else begin
            state_d = tcw_pkg::ST_EXEC;
          end
        end
      end
      tcw_pkg::ST_READ:   state_d = tcw_pkg::ST_IDLE;
      tcw_pkg::ST_SCROLL: begin
        if (cnt_keep) state_d = tcw_pkg::ST_BLANK;
      end
      tcw_pkg::ST_BLANK: begin
        if (cnt_last) state_d = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_EXEC:   state_d = tcw_pkg::ST_IDLE;
      default:            state_d = tcw_pkg::ST_IDLE;
    endcase
  end

  // Outputs, memory ports and datapath next values
  always_comb begin
    cnt_d              = cnt_q;
    cursor_d           = cursor_q;
    col_d              = col_q;
    mem_we_o           = 1'b0;
    mem_waddr_o        = cnt_q;
    mem_wdata_o        = tcw_pkg::BLANK_CELL;
    mem_re_o           = 1'b0;
    mem_raddr_o        = AW'(in_word_i.cell_index);
    stat_o.idle        = 1'b0;
    stat_o.res_valid   = 1'b0;
    stat_o.res_word    = '0;
    unique case (state_q)
      tcw_pkg::ST_CLEAR: begin
        mem_we_o = 1'b1;
        cnt_d    = cnt_q + AW'(1);
      end
      tcw_pkg::ST_IDLE: begin
        stat_o.idle = 1'b1;
        cnt_d       = '0;
        mem_re_o    = accept_i && (in_word_i.kind == tcw_pkg::KIND_READ) && !in_oob;
      end
      tcw_pkg::ST_READ: begin
        stat_o.res_valid       = 1'b1;
        stat_o.res_word.cursor = cursor_q;
        if (!oob_q) begin
          stat_o.res_word.cell_char = mem_rdata_i[tcw_pkg::CHAR_W-1:0];
          stat_o.res_word.cell_attr = mem_rdata_i[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
        end
      end
      tcw_pkg::ST_SCROLL: begin
        // read one row ahead, write the returned cell back in the next cycle
        mem_re_o    = !cnt_keep;
        mem_raddr_o = cnt_q + AW'(tcw_pkg::COLUMNS);
        mem_we_o    = pend_q;
        mem_waddr_o = paddr_q;
        mem_wdata_o = mem_rdata_i;
        if (!cnt_keep) cnt_d = cnt_q + AW'(1);
      end
      tcw_pkg::ST_BLANK: begin
        mem_we_o = 1'b1;
        cnt_d    = cnt_q + AW'(1);
        if (cnt_last) cursor_d = cursor_q - CW'(tcw_pkg::COLUMNS);
      end
      tcw_pkg::ST_EXEC: begin
        if (ch_q == tcw_pkg::CH_NEWLINE) begin
          cursor_d = cursor_q - CW'(col_q) + CW'(tcw_pkg::COLUMNS);
          col_d    = '0;
        end else if (ch_q == tcw_pkg::CH_BACKSPACE) begin
          if (bs_allowed) begin
            cursor_d    = cursor_q - CW'(1);
            col_d       = (col_q == '0) ? LW'(tcw_pkg::COLUMNS - 1) : col_q - LW'(1);
            mem_we_o    = 1'b1;
            mem_waddr_o = AW'(cursor_q - CW'(1));
          end
        end else begin
          cursor_d    = cursor_q + CW'(1);
          col_d       = (col_q == LW'(tcw_pkg::COLUMNS - 1)) ? '0 : col_q + LW'(1);
          mem_we_o    = 1'b1;
          mem_waddr_o = AW'(cursor_q);
          mem_wdata_o = {tcw_pkg::TEXT_ATTR, ch_q};
        end
        stat_o.res_valid       = 1'b1;
        stat_o.res_word.cursor = cursor_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tcw_pkg::ST_CLEAR;
      cnt_q      <= '0;
      cursor_q   <= '0;
      col_q      <= '0;
      in_start_q <= '0;
      pend_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      cursor_q <= cursor_d;
      col_q    <= col_d;
      pend_q   <= (state_q == tcw_pkg::ST_SCROLL) && !cnt_keep;
      if (cfg_we_i) in_start_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    paddr_q <= cnt_q;
    if (accept_i) begin
      ch_q  <= in_word_i.char_code;
      oob_q <= in_oob;
    end
  end

endmodule

[hw/rtl/text_console_writer.sv]
// Top level of the text console writer: screen memory, sequencer and output register.
//
// Text-mode screen of COLUMNS x ROWS cells (char byte low, attribute byte high).
// Input channel (in_valid_i / in_ready_o / in_word_i) takes one word per item:
// kind 0 writes char_code at the cursor (newline, backspace or printable),
// kind 1 reads the cell at cell_index. Every item yields exactly one output
// word (out_valid_o / out_ready_i / out_word_o) carrying the cursor after the
// item and, for reads, the cell contents (zero for writes and out-of-range reads).
// cfg_we_i / cfg_wdata_i set the erase floor: backspace only erases while the
// cursor is above it.
// Result: the result word is loaded into the output register straight from the
// sequencer's read or execute state. A character at a full screen first scrolls:
// a row copy (one memory read and one write per cycle), blanking of the last row,
// and then the execute state that yields its result word. The sequencer takes
// a word in its idle state and reads or executes it before it can take the next.
// Reset: the screen memory is swept to blank cells, one cell per cycle, with
// in_ready_o low; configuration writes are taken throughout.
// When out_ready_i is low the result sits in the output register and no new
// item is accepted until the output register is free again.
module text_console_writer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  tcw_pkg::in_word_t         in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output tcw_pkg::out_word_t        out_word_o,
  input  logic                      cfg_we_i,
  input  logic [tcw_pkg::CUR_W-1:0] cfg_wdata_i
);

  tcw_pkg::ctrl_stat_t stat;

  logic                          mem_we;
  logic [tcw_pkg::ADDR_W-1:0]    mem_waddr;
  logic [tcw_pkg::CELL_W-1:0]    mem_wdata;
  logic                          mem_re;
  logic [tcw_pkg::ADDR_W-1:0]    mem_raddr;
  logic [tcw_pkg::CELL_W-1:0]    mem_rdata;

  logic               out_valid_q, out_valid_d;
  tcw_pkg::out_word_t out_word_q;
  logic               out_free;
  logic               accept;

  // output slot is free when empty or being drained this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = stat.idle && out_free;
  assign accept     = in_valid_i && in_ready_o;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_o      (stat),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // screen store, one cell per entry
  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELL_COUNT)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Result only arrives while the slot is empty, since items are accepted
  // only when the slot is free.
  always_comb begin
    out_valid_d = out_valid_q;
    if (stat.res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.res_valid) out_word_q <= stat.res_word;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[test/text_console_writer_tb.sv]
// Self-checking testbench for the text console writer: directed table, then random phases.
`timescale 1ns / 100ps

module text_console_writer_tb;

  localparam int unsigned HALF_NS     = 6;           // 12 ns clock
  localparam int unsigned WATCHDOG_NS = 60_000_000;  // far beyond the slowest legal run
  localparam int unsigned HOLD_CYCLES = 400;         // long receiver hold-off
  localparam int unsigned PHASE_ITEMS = 76;          // six random phases, ~500 words with the table
  localparam int unsigned NUM_PHASES  = 6;
  localparam int unsigned DIR_ROWS    = 23;

  // Directed stimulus row. When typed is set, the expected word is the one written
  // in the row; otherwise the console predictor supplies it.
  typedef struct {
    logic                       kind;
    logic [tcw_pkg::CHAR_W-1:0] char_code;
    logic [tcw_pkg::IDX_W-1:0]  cell_index;
    int                         reps;
    bit                         typed;
    logic [tcw_pkg::CUR_W-1:0]  cur;
    logic [tcw_pkg::CHAR_W-1:0] chr;
    logic [tcw_pkg::CHAR_W-1:0] attr;
  } stim_row_t;

  // Drive signals start at known values at time zero.
  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  tcw_pkg::in_word_t          in_word   = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  tcw_pkg::out_word_t         out_word;
  logic                       cfg_we    = 1'b0;
  logic [tcw_pkg::CUR_W-1:0]  cfg_wdata = '0;

  // Console predictor state: screen, cursor and the backspace floor.
  logic [tcw_pkg::CELL_W-1:0] screen_model [tcw_pkg::CELL_COUNT];
  int unsigned                cursor_model;
  int unsigned                erase_floor;

  // Expected output words, oldest first.
  tcw_pkg::out_word_t         due_words [$];
  tcw_pkg::out_word_t         want_word;

  // Idle rates (percent of cycles), set per phase by the main sequence.
  int unsigned          send_idle_pct = 8;
  int unsigned          recv_idle_pct = 58;

  // Receiver hold-off handshake: main bumps hold_req, receiver process acks.
  int unsigned          hold_req  = 0;
  int unsigned          hold_ack  = 0;
  int unsigned          hold_left = 0;

  // Run statistics.
  int unsigned          err_cnt     = 0;
  int unsigned          words_sent  = 0;
  int unsigned          reads_sent  = 0;
  int unsigned          scroll_cnt  = 0;
  int unsigned          words_seen  = 0;
  int unsigned          floor_sets  = 0;

  stim_row_t dir_rows [DIR_ROWS] = '{
    // blank screen right after the clearing sweep
    '{tcw_pkg::KIND_READ, 8'h00, 11'd0, 1, 1'b1, 11'd0,
      tcw_pkg::CH_SPACE, tcw_pkg::BLANK_ATTR},
    '{tcw_pkg::KIND_READ, 8'hFF, 11'd1999, 1, 1'b1, 11'd0,
      tcw_pkg::CH_SPACE, tcw_pkg::BLANK_ATTR},
    // reads past the last cell return zeros
    '{tcw_pkg::KIND_READ, 8'h00, 11'd2000, 1, 1'b1, 11'd0, 8'h00, 8'h00},
    '{tcw_pkg::KIND_READ, 8'hFF, 11'd2047, 1, 1'b1, 11'd0, 8'h00, 8'h00},
    // backspace at the floor does nothing
    '{tcw_pkg::KIND_WRITE, tcw_pkg::CH_BACKSPACE, 11'd2047, 1, 1'b1, 11'd0, 8'h00, 8'h00},
    // byte extremes are printed
    '{tcw_pkg::KIND_WRITE, 8'h00, 11'd0, 1, 1'b1, 11'd1, 8'h00, 8'h00},
    '{tcw_pkg::KIND_WRITE, 8'hFF, 11'd2047, 1, 1'b1, 11'd2, 8'h00, 8'h00},
    '{tcw_pkg::KIND_READ, 8'h5A, 11'd0, 1, 1'b1, 11'd2, 8'h00, tcw_pkg::TEXT_ATTR},
    '{tcw_pkg::KIND_READ, 8'h00, 11'd1, 1, 1'b1, 11'd2, 8'hFF, tcw_pkg::TEXT_ATTR},
    // backspace above the floor erases
    '{tcw_pkg::KIND_WRITE, tcw_pkg::CH_BACKSPACE, 11'd0, 1, 1'b1, 11'd1, 8'h00, 8'h00},
    '{tcw_pkg::KIND_READ, 8'h00, 11'd1, 1, 1'b1, 11'd1,
      tcw_pkg::CH_SPACE, tcw_pkg::BLANK_ATTR},
    '{tcw_pkg::KIND_WRITE, tcw_pkg::CH_NEWLINE, 11'd0, 1, 1'b1, 11'd80, 8'h00, 8'h00},
    // walk down to the last row
    '{tcw_pkg::KIND_WRITE, 8'h41, 11'd0, 1, 1'b0, 11'd0, 8'h00, 8'h00},
    '{tcw_pkg::KIND_WRITE, tcw_pkg::CH_NEWLINE, 11'd0, 23, 1'b0, 11'd0, 8'h00, 8'h00},
    '{tcw_pkg::KIND_WRITE, 8'h55, 11'd0, 2, 1'b0, 11'd0, 8'h00, 8'h00},
    // newline on the last row parks the cursor at the cell count
    '{tcw_pkg::KIND_WRITE, tcw_pkg::CH_NEWLINE, 11'd0, 1, 1'b1,
      11'(tcw_pkg::CELL_COUNT), 8'h00, 8'h00},
    '{tcw_pkg::KIND_READ, 8'h00, 11'd1920, 1, 1'b0, 11'd0, 8'h00, 8'h00},
    // next character scrolls first
    '{tcw_pkg::KIND_WRITE, 8'h5A, 11'd0, 1, 1'b0, 11'd0, 8'h00, 8'h00},
    '{tcw_pkg::KIND_READ, 8'h00, 11'd1840, 1, 1'b0, 11'd0, 8'h00, 8'h00},
    '{tcw_pkg::KIND_READ, 8'h00, 11'd1999, 1, 1'b0, 11'd0, 8'h00, 8'h00},
    // backspace at a full screen: scroll, then erase
    '{tcw_pkg::KIND_WRITE, tcw_pkg::CH_NEWLINE, 11'd0, 1, 1'b0, 11'd0, 8'h00, 8'h00},
    '{tcw_pkg::KIND_WRITE, tcw_pkg::CH_BACKSPACE, 11'd0, 1, 1'b0, 11'd0, 8'h00, 8'h00},
    '{tcw_pkg::KIND_WRITE, 8'h7F, 11'h555, 1, 1'b0, 11'd0, 8'h00, 8'h00}
  };

  text_console_writer uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #HALF_NS clk = 1'b1;
    #HALF_NS clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result word ends up here.
  initial begin
    #WATCHDOG_NS;
    $display("text_console_writer regression: fail");
    $finish;
  end

  // Console predictor: applies one input word and returns the result word.
  function automatic tcw_pkg::out_word_t console_step(tcw_pkg::in_word_t w);
    tcw_pkg::out_word_t r;
    int unsigned        i;
    r = '0;
    if (w.kind == tcw_pkg::KIND_WRITE) begin
      // cursor past the screen: scroll before the character takes effect
      if (cursor_model >= tcw_pkg::CELL_COUNT) begin
        for (i = 0; i < tcw_pkg::KEEP_COUNT; i++) begin
          screen_model[i] = screen_model[i + tcw_pkg::COLUMNS];
        end
        for (i = tcw_pkg::KEEP_COUNT; i < tcw_pkg::CELL_COUNT; i++) begin
          screen_model[i] = tcw_pkg::BLANK_CELL;
        end
        cursor_model = (cursor_model >= tcw_pkg::COLUMNS) ?
                       cursor_model - tcw_pkg::COLUMNS : 0;
        scroll_cnt++;
      end
      if (w.char_code == tcw_pkg::CH_NEWLINE) begin
        cursor_model += tcw_pkg::COLUMNS - (cursor_model % tcw_pkg::COLUMNS);
      end else if (w.char_code == tcw_pkg::CH_BACKSPACE) begin
        if (cursor_model > erase_floor) begin
          cursor_model--;
          if (cursor_model < tcw_pkg::CELL_COUNT) begin
            screen_model[cursor_model] = tcw_pkg::BLANK_CELL;
          end
        end
      end else if (cursor_model < tcw_pkg::CELL_COUNT) begin
        screen_model[cursor_model] = {tcw_pkg::TEXT_ATTR, w.char_code};
        cursor_model++;
      end
    end else if (w.cell_index < tcw_pkg::CELL_COUNT) begin
      r.cell_char = screen_model[w.cell_index][tcw_pkg::CHAR_W-1:0];
      r.cell_attr = screen_model[w.cell_index][tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
    end
    r.cursor = tcw_pkg::CUR_W'(cursor_model);
    return r;
  endfunction

  // Random console traffic: mostly typing with newlines and backspaces, some reads,
  // a few reads past the screen. Unused fields carry random bits.
  function automatic tcw_pkg::in_word_t random_word();
    tcw_pkg::in_word_t w;
    int unsigned       pick;
    w.kind       = tcw_pkg::KIND_WRITE;
    w.char_code  = tcw_pkg::CHAR_W'($urandom);
    w.cell_index = tcw_pkg::IDX_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      w.kind = tcw_pkg::KIND_READ;
      if ($urandom_range(0, 9) == 0) begin
        w.cell_index = tcw_pkg::IDX_W'($urandom_range(tcw_pkg::CELL_COUNT, 2047));
      end else begin
        w.cell_index = tcw_pkg::IDX_W'($urandom_range(0, tcw_pkg::CELL_COUNT - 1));
      end
    end else if (pick < 37) begin
      w.char_code = tcw_pkg::CH_NEWLINE;
    end else if (pick < 50) begin
      w.char_code = tcw_pkg::CH_BACKSPACE;
    end
    return w;
  endfunction

  // Offer one word, honoring the sender idle rate; predict it at acceptance.
  task automatic push_word(tcw_pkg::in_word_t w, bit typed, tcw_pkg::out_word_t typed_word);
    int unsigned        gap;
    tcw_pkg::out_word_t pred;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    pred = console_step(w);
    due_words.push_back(typed ? typed_word : pred);
    words_sent++;
    if (w.kind == tcw_pkg::KIND_READ) reads_sent++;
  endtask

  // Block is idle once every result word is back; a little slack for the last one.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_floor(int unsigned v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= tcw_pkg::CUR_W'(v);
    @(negedge clk);
    cfg_we    <= 1'b0;
    erase_floor = v;
    floor_sets++;
  endtask

  // Receiver: random stalls, or a long hold-off on request so the block backs up.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result checker: every accepted output word against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_words.size() == 0) begin
        $error("result word with nothing expected: cursor=%0d char=%02h attr=%02h",
               out_word.cursor, out_word.cell_char, out_word.cell_attr);
        err_cnt++;
      end else begin
        want_word = due_words.pop_front();
        words_seen++;
        if (out_word.cursor !== want_word.cursor) begin
          $error("cursor: expected %0d, got %0d", want_word.cursor, out_word.cursor);
          err_cnt++;
        end
        if (out_word.cell_char !== want_word.cell_char) begin
          $error("cell_char: expected %02h, got %02h", want_word.cell_char, out_word.cell_char);
          err_cnt++;
        end
        if (out_word.cell_attr !== want_word.cell_attr) begin
          $error("cell_attr: expected %02h, got %02h", want_word.cell_attr, out_word.cell_attr);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    tcw_pkg::out_word_t typed_word;
    int unsigned        floor_val;
    for (int i = 0; i < tcw_pkg::CELL_COUNT; i++) screen_model[i] = tcw_pkg::BLANK_CELL;
    cursor_model = 0;
    erase_floor  = 0;

    // Reset is released on a falling edge. The block then sweeps its
    // screen store with in_ready low; the floor register is written meanwhile.
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    set_floor(0);

    // Directed table: sender idles 8%, receiver 58%.
    foreach (dir_rows[r]) begin
      typed_word = tcw_pkg::out_word_t'{cursor: dir_rows[r].cur, cell_char: dir_rows[r].chr,
                                        cell_attr: dir_rows[r].attr};
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        push_word(tcw_pkg::in_word_t'{kind: dir_rows[r].kind,
                                      char_code: dir_rows[r].char_code,
                                      cell_index: dir_rows[r].cell_index},
                  dir_rows[r].typed, typed_word);
      end
    end
    wait_for_results();

    // Random phases: two per idle mode, each under a new backspace floor
    // (both extremes, a mid value with all low bits set, the live cursor, random, the cursor less 40).
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0, 1: begin send_idle_pct = 8;  recv_idle_pct = 58; end
        2, 3: begin send_idle_pct = 58; recv_idle_pct = 8;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (p)
        0: floor_val = tcw_pkg::CELL_COUNT;
        1: floor_val = 1023;
        2: floor_val = cursor_model;      // prompt at the cursor, like a shell
        3: floor_val = 0;
        4: floor_val = $urandom_range(0, tcw_pkg::CELL_COUNT);
        default: floor_val = (cursor_model > 40) ? cursor_model - 40 : 0;
      endcase
      set_floor(floor_val);
      // Long output stall while the sender keeps offering: the block must back up.
      if (p == 2) hold_req++;
      for (int n = 0; n < PHASE_ITEMS; n++) push_word(random_word(), 1'b0, '0);
      wait_for_results();
    end

    $display("covered %0d input words (%0d reads, %0d scrolls), %0d result words checked,",
             words_sent, reads_sent, scroll_cnt, words_seen);
    $display("under %0d floor settings and three idle patterns with one long output stall",
             floor_sets);
    if (err_cnt == 0) begin
      $display("text_console_writer regression: pass");
    end else begin
      $display("text_console_writer regression: fail");
    end
    $finish;
  end

endmodule

[text_console_writer.f]
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/text_console_writer.sv
test/text_console_writer_tb.sv
